@@ sv/dtcr_pkg.sv @@
package dtcr_pkg;

    // Input field widths
    localparam int COORD_BITS = 12;
    localparam int DEPTH_BITS = 16;

    // Fixed field widths
    localparam int INTR_W    = 16;
    localparam int ROT_W     = 16;
    localparam int T_W       = 20;
    localparam int CC_W      = 12;
    localparam int IDX_W     = 24;
    localparam int OUT_D_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_D_W   = 64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_INTR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_INTR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_SIZE = 3'd6;

    // Normalised coordinate divider
    localparam int MAG_W   = (COORD_BITS + 4 > INTR_W) ? COORD_BITS + 4 : INTR_W;
    localparam int DIFF_W  = MAG_W + 1;
    localparam int NDEN_W  = INTR_W + 1;
    localparam int NDIV_NW = MAG_W + NDEN_W;
    localparam int Q_LO_W  = NDEN_W;
    localparam int Q_HI_W  = NDIV_NW - Q_LO_W;

    // Back-projection
    localparam int PM_W     = DEPTH_BITS + NDIV_NW;
    localparam int XM_W     = PM_W - 11;
    localparam int X_W      = XM_W + 1;
    localparam int X_LO_W   = 20;
    localparam int X_HI_W   = X_W - X_LO_W;
    localparam int Z_W      = DEPTH_BITS + 4;
    localparam int XRND     = 2048;

    // Rigid transform
    localparam int RL_W  = ROT_W + X_LO_W + 1;
    localparam int RH_W  = ROT_W + X_HI_W;
    localparam int RZ_W  = ROT_W + Z_W + 1;
    localparam int S_W   = X_W + 18;
    localparam int SQ_W  = S_W - 14;
    localparam int SRND  = 8192;
    localparam int P_MAG_W = 44;
    localparam int P_W     = P_MAG_W + 2;
    localparam logic [63:0] P_LIMIT = (64'd1 << P_MAG_W) - 64'd1;

    // Projection
    localparam int P_LO_W  = 23;
    localparam int P_HI_W  = P_W - P_LO_W;
    localparam int JL_W    = P_LO_W + 1 + INTR_W + 1;
    localparam int JH_W    = P_HI_W + INTR_W + 1;
    localparam int NC_W    = 64;
    localparam int PDEN_W  = P_MAG_W + 5;
    localparam int PDIV_N  = CC_W + 1;

    // Stage numbers, counted from the input registers
    localparam int K_NQ   = NDIV_NW;
    localparam int K_X    = K_NQ + 3;
    localparam int K_RQ   = K_NQ + 7;
    localparam int K_P    = K_NQ + 8;
    localparam int K_JN   = K_NQ + 12;
    localparam int K_DQ   = K_JN + PDIV_N;
    localparam int SIDE_N = K_DQ + 1;

    typedef struct packed {
        logic                  ok;
        logic                  last;
        logic [DEPTH_BITS-1:0] d;
    } side_t;

endpackage

@@ sv/dtcr_ndiv.sv @@
module dtcr_ndiv import dtcr_pkg::*;
(
    input  logic               clk,
    input  logic [NDIV_NW-1:0] num,
    input  logic [NDEN_W-1:0]  den,
    input  logic               neg_in,
    output logic [NDIV_NW-1:0] quot,
    output logic               neg_out
);

    // Restoring divider, one quotient bit per stage
    logic [NDEN_W-1:0]  rem_reg  [NDIV_NW];
    logic [NDEN_W-1:0]  rem_next [NDIV_NW];
    logic [NDIV_NW-1:0] num_reg  [NDIV_NW];
    logic [NDIV_NW-1:0] num_next [NDIV_NW];
    logic [NDIV_NW-1:0] quot_reg [NDIV_NW];
    logic [NDIV_NW-1:0] quot_next[NDIV_NW];
    logic               neg_reg  [NDIV_NW];
    logic               neg_next [NDIV_NW];

    logic [NDEN_W-1:0]  rem_in [NDIV_NW];
    logic [NDIV_NW-1:0] num_in [NDIV_NW];
    logic [NDIV_NW-1:0] quot_in[NDIV_NW];
    logic               neg_i  [NDIV_NW];
    logic [NDEN_W:0]    trial  [NDIV_NW];
    logic [NDEN_W:0]    sub    [NDIV_NW];
    logic               ge     [NDIV_NW];

    always_comb
    begin
        for (int j = 0; j < NDIV_NW; j++)
        begin
            if (j == 0)
            begin
                rem_in[j]  = '0;
                num_in[j]  = num;
                quot_in[j] = '0;
                neg_i[j]   = neg_in;
            end
            else
            begin
                rem_in[j]  = rem_reg[j-1];
                num_in[j]  = num_reg[j-1];
                quot_in[j] = quot_reg[j-1];
                neg_i[j]   = neg_reg[j-1];
            end
            trial[j]     = {rem_in[j], num_in[j][NDIV_NW-1]};
            ge[j]        = trial[j] >= {1'b0, den};
            sub[j]       = trial[j] - {1'b0, den};
            rem_next[j]  = ge[j] ? sub[j][NDEN_W-1:0] : trial[j][NDEN_W-1:0];
            num_next[j]  = num_in[j] << 1;
            quot_next[j] = {quot_in[j][NDIV_NW-2:0], ge[j]};
            neg_next[j]  = neg_i[j];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NDIV_NW; j++)
        begin
            rem_reg[j]  <= rem_next[j];
            num_reg[j]  <= num_next[j];
            quot_reg[j] <= quot_next[j];
            neg_reg[j]  <= neg_next[j];
        end
    end

    assign quot    = quot_reg[NDIV_NW-1];
    assign neg_out = neg_reg[NDIV_NW-1];

endmodule

@@ sv/dtcr_pdiv.sv @@
module dtcr_pdiv import dtcr_pkg::*;
(
    input  logic              clk,
    input  logic [NC_W-1:0]   num,
    input  logic [PDEN_W-1:0] den,
    input  logic              neg_in,
    output logic [CC_W-1:0]   quot,
    output logic              ovf,
    output logic              neg_out
);

    // Stage 0 flags a quotient of 2^CC_W or more, then one bit per stage
    logic [NC_W-1:0]   rem_reg  [PDIV_N];
    logic [NC_W-1:0]   rem_next [PDIV_N];
    logic [PDEN_W-1:0] den_reg  [PDIV_N];
    logic [PDEN_W-1:0] den_next [PDIV_N];
    logic [CC_W-1:0]   quot_reg [PDIV_N];
    logic [CC_W-1:0]   quot_next[PDIV_N];
    logic              ovf_reg  [PDIV_N];
    logic              ovf_next [PDIV_N];
    logic              neg_reg  [PDIV_N];
    logic              neg_next [PDIV_N];

    logic [NC_W-1:0]   sub [PDIV_N];
    logic              ge  [PDIV_N];

    always_comb
    begin
        sub[0]       = NC_W'(den) << CC_W;
        ge[0]        = num >= sub[0];
        rem_next[0]  = num;
        den_next[0]  = den;
        quot_next[0] = '0;
        ovf_next[0]  = ge[0];
        neg_next[0]  = neg_in;
        for (int i = 1; i < PDIV_N; i++)
        begin
            sub[i]       = NC_W'(den_reg[i-1]) << (CC_W - i);
            ge[i]        = rem_reg[i-1] >= sub[i];
            rem_next[i]  = ge[i] ? rem_reg[i-1] - sub[i] : rem_reg[i-1];
            den_next[i]  = den_reg[i-1];
            quot_next[i] = {quot_reg[i-1][CC_W-2:0], ge[i]};
            ovf_next[i]  = ovf_reg[i-1];
            neg_next[i]  = neg_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PDIV_N; i++)
        begin
            rem_reg[i]  <= rem_next[i];
            den_reg[i]  <= den_next[i];
            quot_reg[i] <= quot_next[i];
            ovf_reg[i]  <= ovf_next[i];
            neg_reg[i]  <= neg_next[i];
        end
    end

    assign quot    = quot_reg[PDIV_N-1];
    assign ovf     = ovf_reg[PDIV_N-1];
    assign neg_out = neg_reg[PDIV_N-1];

endmodule

@@ sv/depth_to_color_registration_top.sv @@
// Depth-to-colour registration: one depth pixel in, one colour-buffer write
// command out, fully pipelined.
// Input channel: a beat (depth_col, depth_row, depth_mm, depth_valid,
// frame_last) is taken at every rising edge with start high; busy is always
// low, so a pixel may enter on every clock cycle.
// Output channel: result_valid strobes for one cycle per input beat, in
// order, carrying write_enable, color_col, color_row, color_index,
// depth_out_mm and frame_end. Suppressed writes still produce a beat with
// write_enable low and the address fields zero; frame_end always follows.
// The result strobe is registered from the valid bit of stage K_DQ.
// Throughput: one beat per cycle, set by the two bit-serial dividers
// (normalised coordinate and projection) being unrolled into one stage per
// quotient bit.
// Receiver cannot stall; results are simply presented for one cycle.
// Configuration: cfg_valid/cfg_ready write port, cfg_ready always high;
// write only while no pixel is in flight.
// Reset: asynchronous, active low; clears the valid pipeline and loads the
// default registers (identity rotation, 640 x 480 colour frame).
module depth_to_color_registration_top import dtcr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_D_W-1:0]    cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] depth_col,
    input  logic [COORD_BITS-1:0] depth_row,
    input  logic [DEPTH_BITS-1:0] depth_mm,
    input  logic                  depth_valid,
    input  logic                  frame_last,
    output logic                  result_valid,
    output logic                  write_enable,
    output logic [CC_W-1:0]       color_col,
    output logic [CC_W-1:0]       color_row,
    output logic [IDX_W-1:0]      color_index,
    output logic [OUT_D_W-1:0]    depth_out_mm,
    output logic                  frame_end
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [63:0] dintr_reg;
    logic [63:0] cintr_reg;
    logic [47:0] rot_reg [3];
    logic [59:0] trans_reg;
    logic [23:0] csize_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dintr_reg  <= '0;
            cintr_reg  <= '0;
            rot_reg[0] <= 48'd16384;
            rot_reg[1] <= 48'd1073741824;
            rot_reg[2] <= 48'd70368744177664;
            trans_reg  <= '0;
            csize_reg  <= 24'd1966720;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEPTH_INTR: dintr_reg  <= cfg_data;
                REG_COLOR_INTR: cintr_reg  <= cfg_data;
                REG_ROT_ROW0:   rot_reg[0] <= cfg_data[47:0];
                REG_ROT_ROW1:   rot_reg[1] <= cfg_data[47:0];
                REG_ROT_ROW2:   rot_reg[2] <= cfg_data[47:0];
                REG_TRANS:      trans_reg  <= cfg_data[59:0];
                REG_COLOR_SIZE: csize_reg  <= cfg_data[23:0];
                default:        ;
            endcase
        end
    end

    logic [INTR_W-1:0] dfx, dfy, dcx, dcy, cfx, cfy, ccx, ccy;
    logic [CC_W-1:0]   frame_w, frame_h;
    logic signed [ROT_W-1:0] rot_e [3][3];
    logic signed [T_W-1:0]   trans_e [3];

    assign dfx     = dintr_reg[15:0];
    assign dfy     = dintr_reg[31:16];
    assign dcx     = dintr_reg[47:32];
    assign dcy     = dintr_reg[63:48];
    assign cfx     = cintr_reg[15:0];
    assign cfy     = cintr_reg[31:16];
    assign ccx     = cintr_reg[47:32];
    assign ccy     = cintr_reg[63:48];
    assign frame_w = csize_reg[11:0];
    assign frame_h = csize_reg[23:12];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rot_e[i][k] = $signed(rot_reg[i][16*k +: 16]);
            end
            trans_e[i] = $signed(trans_reg[20*i +: 20]);
        end
    end

    // ---------------------------------------------------------------
    // Valid bits and per-pixel sideband travel with the data
    // ---------------------------------------------------------------
    logic  vld_reg  [SIDE_N];
    side_t side_reg [SIDE_N];
    side_t side_next[SIDE_N];
    logic  pz_pos;

    always_comb
    begin
        side_next[0].ok   = depth_valid && (dfx != '0) && (dfy != '0);
        side_next[0].last = frame_last;
        side_next[0].d    = depth_mm;
        for (int k = 1; k < SIDE_N; k++)
        begin
            side_next[k] = side_reg[k-1];
        end
        // point not in front of the colour camera suppresses the write
        side_next[K_P].ok = side_reg[K_P-1].ok && pz_pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SIDE_N; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= start && !busy;
            for (int k = 1; k < SIDE_N; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SIDE_N; k++)
        begin
            side_reg[k] <= side_next[k];
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: centred pixel coordinate, numerator for the rounded
    // divide by the depth focal length (|n| * 2^17 + f over 2f)
    // ---------------------------------------------------------------
    logic signed [DIFF_W-1:0] diffx, diffy;
    logic [MAG_W-1:0]   magx, magy;
    logic [NDIV_NW-1:0] numx_reg, numx_next, numy_reg, numy_next;
    logic               negx_reg, negx_next, negy_reg, negy_next;

    always_comb
    begin
        diffx     = $signed(DIFF_W'({depth_col, 4'b0000})) - $signed(DIFF_W'(dcx));
        diffy     = $signed(DIFF_W'({depth_row, 4'b0000})) - $signed(DIFF_W'(dcy));
        magx      = diffx[DIFF_W-1] ? MAG_W'(-diffx) : MAG_W'(diffx);
        magy      = diffy[DIFF_W-1] ? MAG_W'(-diffy) : MAG_W'(diffy);
        numx_next = {magx, 1'b0, dfx};
        numy_next = {magy, 1'b0, dfy};
        negx_next = diffx[DIFF_W-1];
        negy_next = diffy[DIFF_W-1];
    end

    always_ff @(posedge clk)
    begin
        numx_reg <= numx_next;
        numy_reg <= numy_next;
        negx_reg <= negx_next;
        negy_reg <= negy_next;
    end

    logic [NDIV_NW-1:0] qx, qy;
    logic               nqx, nqy;

    dtcr_ndiv u_ndiv_x
    (
        .clk     (clk),
        .num     (numx_reg),
        .den     ({dfx, 1'b0}),
        .neg_in  (negx_reg),
        .quot    (qx),
        .neg_out (nqx)
    );

    dtcr_ndiv u_ndiv_y
    (
        .clk     (clk),
        .num     (numy_reg),
        .den     ({dfy, 1'b0}),
        .neg_in  (negy_reg),
        .quot    (qy),
        .neg_out (nqy)
    );

    // ---------------------------------------------------------------
    // Scale by depth: X = rdiv(d * nx, 4096), split multiply
    // ---------------------------------------------------------------
    logic [DEPTH_BITS+Q_LO_W-1:0] pxl_reg, pxl_next, pyl_reg, pyl_next;
    logic [DEPTH_BITS+Q_HI_W-1:0] pxh_reg, pxh_next, pyh_reg, pyh_next;
    logic nxp_reg, nyp_reg;

    always_comb
    begin
        pxl_next = side_reg[K_NQ].d * qx[Q_LO_W-1:0];
        pxh_next = side_reg[K_NQ].d * qx[NDIV_NW-1:Q_LO_W];
        pyl_next = side_reg[K_NQ].d * qy[Q_LO_W-1:0];
        pyh_next = side_reg[K_NQ].d * qy[NDIV_NW-1:Q_LO_W];
    end

    always_ff @(posedge clk)
    begin
        pxl_reg <= pxl_next;
        pxh_reg <= pxh_next;
        pyl_reg <= pyl_next;
        pyh_reg <= pyh_next;
        nxp_reg <= nqx;
        nyp_reg <= nqy;
    end

    logic [PM_W-1:0] mx_reg, mx_next, my_reg, my_next;
    logic nxm_reg, nym_reg;

    always_comb
    begin
        mx_next = (PM_W'(pxh_reg) << Q_LO_W) + PM_W'(pxl_reg);
        my_next = (PM_W'(pyh_reg) << Q_LO_W) + PM_W'(pyl_reg);
    end

    always_ff @(posedge clk)
    begin
        mx_reg  <= mx_next;
        my_reg  <= my_next;
        nxm_reg <= nxp_reg;
        nym_reg <= nyp_reg;
    end

    logic [PM_W:0]   rx, ry;
    logic [XM_W-1:0] xm, ym;
    logic signed [X_W-1:0] x_reg, x_next, y_reg, y_next;

    always_comb
    begin
        rx     = (PM_W+1)'(mx_reg) + (PM_W+1)'(XRND);
        ry     = (PM_W+1)'(my_reg) + (PM_W+1)'(XRND);
        xm     = rx[PM_W:12];
        ym     = ry[PM_W:12];
        x_next = nxm_reg ? -$signed({1'b0, xm}) : $signed({1'b0, xm});
        y_next = nym_reg ? -$signed({1'b0, ym}) : $signed({1'b0, ym});
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    // ---------------------------------------------------------------
    // Rigid transform: R * [X Y Z] + T * 2^18, then rdiv by 2^14
    // ---------------------------------------------------------------
    logic signed [RL_W-1:0] rxl_reg [3], rxl_next [3], ryl_reg [3], ryl_next [3];
    logic signed [RH_W-1:0] rxh_reg [3], rxh_next [3], ryh_reg [3], ryh_next [3];
    logic signed [RZ_W-1:0] rz_reg  [3], rz_next  [3];
    logic [Z_W-1:0]         zval;

    always_comb
    begin
        zval = {side_reg[K_X].d, 4'b0000};
        for (int i = 0; i < 3; i++)
        begin
            rxl_next[i] = rot_e[i][0] * $signed({1'b0, x_reg[X_LO_W-1:0]});
            rxh_next[i] = rot_e[i][0] * $signed(x_reg[X_W-1:X_LO_W]);
            ryl_next[i] = rot_e[i][1] * $signed({1'b0, y_reg[X_LO_W-1:0]});
            ryh_next[i] = rot_e[i][1] * $signed(y_reg[X_W-1:X_LO_W]);
            rz_next[i]  = rot_e[i][2] * $signed({1'b0, zval});
        end
    end

    logic signed [S_W-1:0] sa_reg [3], sa_next [3];
    logic signed [S_W-1:0] sb_reg [3], sb_next [3];
    logic signed [S_W-1:0] sc_reg [3], sc_next [3];
    logic signed [S_W-1:0] s_reg  [3], s_next  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sa_next[i] = (S_W'(rxh_reg[i]) <<< X_LO_W) + S_W'(rxl_reg[i]);
            sb_next[i] = (S_W'(ryh_reg[i]) <<< X_LO_W) + S_W'(ryl_reg[i]);
            sc_next[i] = S_W'(rz_reg[i]) + (S_W'(trans_e[i]) <<< 18);
            s_next[i]  = sa_reg[i] + sb_reg[i] + sc_reg[i];
        end
    end

    logic [S_W-1:0]  smag [3];
    logic [S_W-1:0]  srnd [3];
    logic [SQ_W-1:0] sq_reg [3], sq_next [3];
    logic            sn_reg [3], sn_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            smag[i]    = s_reg[i][S_W-1] ? S_W'(-s_reg[i]) : S_W'(s_reg[i]);
            srnd[i]    = smag[i] + S_W'(SRND);
            sq_next[i] = srnd[i][S_W-1:14];
            sn_next[i] = s_reg[i][S_W-1];
        end
    end

    // saturate to +-(2^44 - 1) and restore the sign
    logic [P_MAG_W-1:0]    pclamp [3];
    logic signed [P_W-1:0] p_reg [3], p_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pclamp[i] = (64'(sq_reg[i]) > P_LIMIT) ? P_LIMIT[P_MAG_W-1:0]
                                                     : P_MAG_W'(sq_reg[i]);
            p_next[i] = sn_reg[i] ? -$signed({2'b00, pclamp[i]})
                                  : $signed({2'b00, pclamp[i]});
        end
        pz_pos = !sn_reg[2] && (sq_reg[2] != '0);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            rxl_reg[i] <= rxl_next[i];
            rxh_reg[i] <= rxh_next[i];
            ryl_reg[i] <= ryl_next[i];
            ryh_reg[i] <= ryh_next[i];
            rz_reg[i]  <= rz_next[i];
            sa_reg[i]  <= sa_next[i];
            sb_reg[i]  <= sb_next[i];
            sc_reg[i]  <= sc_next[i];
            s_reg[i]   <= s_next[i];
            sq_reg[i]  <= sq_next[i];
            sn_reg[i]  <= sn_next[i];
            p_reg[i]   <= p_next[i];
        end
    end

    // ---------------------------------------------------------------
    // Projection numerators: Px*CFX + CCX*Pz, Py*CFY + CCY*Pz
    // slot 0 px*cfx, 1 pz*ccx, 2 py*cfy, 3 pz*ccy
    // ---------------------------------------------------------------
    logic signed [P_W-1:0]    jp_src [4];
    logic signed [INTR_W:0]   jk_src [4];
    logic signed [JL_W-1:0]   jl_reg [4], jl_next [4];
    logic signed [JH_W-1:0]   jh_reg [4], jh_next [4];
    logic signed [NC_W-1:0]   ja_reg [4], ja_next [4];
    logic signed [P_W-1:0]    pz_jp_reg, pz_ja_reg, pz_js_reg;

    always_comb
    begin
        jp_src[0] = p_reg[0];
        jp_src[1] = p_reg[2];
        jp_src[2] = p_reg[1];
        jp_src[3] = p_reg[2];
        jk_src[0] = $signed({1'b0, cfx});
        jk_src[1] = $signed({1'b0, ccx});
        jk_src[2] = $signed({1'b0, cfy});
        jk_src[3] = $signed({1'b0, ccy});
        for (int i = 0; i < 4; i++)
        begin
            jl_next[i] = $signed({1'b0, jp_src[i][P_LO_W-1:0]}) * jk_src[i];
            jh_next[i] = $signed(jp_src[i][P_W-1:P_LO_W]) * jk_src[i];
            ja_next[i] = (NC_W'(jh_reg[i]) <<< P_LO_W) + NC_W'(jl_reg[i]);
        end
    end

    logic signed [NC_W-1:0] nc_reg, nc_next, nr_reg, nr_next;

    always_comb
    begin
        nc_next = ja_reg[0] + ja_reg[1];
        nr_next = ja_reg[2] + ja_reg[3];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            jl_reg[i] <= jl_next[i];
            jh_reg[i] <= jh_next[i];
            ja_reg[i] <= ja_next[i];
        end
        nc_reg    <= nc_next;
        nr_reg    <= nr_next;
        pz_jp_reg <= p_reg[2];
        pz_ja_reg <= pz_jp_reg;
        pz_js_reg <= pz_ja_reg;
    end

    // rounded divide by m = 16*Pz: (2|n| + m) over 2m
    logic [NC_W-1:0]   magc, magr;
    logic [NC_W-1:0]   dnc_reg, dnc_next, dnr_reg, dnr_next;
    logic [PDEN_W-1:0] dden_reg, dden_next;
    logic              dnegc_reg, dnegr_reg;

    always_comb
    begin
        magc      = nc_reg[NC_W-1] ? NC_W'(-nc_reg) : NC_W'(nc_reg);
        magr      = nr_reg[NC_W-1] ? NC_W'(-nr_reg) : NC_W'(nr_reg);
        dnc_next  = {magc[NC_W-2:0], 1'b0} + NC_W'({pz_js_reg[P_MAG_W-1:0], 4'b0000});
        dnr_next  = {magr[NC_W-2:0], 1'b0} + NC_W'({pz_js_reg[P_MAG_W-1:0], 4'b0000});
        dden_next = {pz_js_reg[P_MAG_W-1:0], 5'b00000};
    end

    always_ff @(posedge clk)
    begin
        dnc_reg   <= dnc_next;
        dnr_reg   <= dnr_next;
        dden_reg  <= dden_next;
        dnegc_reg <= nc_reg[NC_W-1];
        dnegr_reg <= nr_reg[NC_W-1];
    end

    logic [CC_W-1:0] qc, qr;
    logic            ovfc, ovfr, negc, negr;

    dtcr_pdiv u_pdiv_col
    (
        .clk     (clk),
        .num     (dnc_reg),
        .den     (dden_reg),
        .neg_in  (dnegc_reg),
        .quot    (qc),
        .ovf     (ovfc),
        .neg_out (negc)
    );

    dtcr_pdiv u_pdiv_row
    (
        .clk     (clk),
        .num     (dnr_reg),
        .den     (dden_reg),
        .neg_in  (dnegr_reg),
        .quot    (qr),
        .ovf     (ovfr),
        .neg_out (negr)
    );

    // ---------------------------------------------------------------
    // Bounds check against the colour frame, buffer address
    // a negative quotient is only in range when it rounds to zero
    // ---------------------------------------------------------------
    logic col_ok, row_ok;
    logic              result_valid_reg;
    logic              we_reg, we_next;
    logic [CC_W-1:0]   col_reg, col_next, row_reg, row_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [OUT_D_W-1:0] dout_reg, dout_next;
    logic              fend_reg;

    always_comb
    begin
        col_ok    = !ovfc && (!negc || (qc == '0)) && (qc < frame_w);
        row_ok    = !ovfr && (!negr || (qr == '0)) && (qr < frame_h);
        we_next   = side_reg[K_DQ].ok && col_ok && row_ok;
        col_next  = we_next ? qc : '0;
        row_next  = we_next ? qr : '0;
        idx_next  = we_next ? IDX_W'(qr) * IDX_W'(frame_w) + IDX_W'(qc) : '0;
        dout_next = we_next ? OUT_D_W'(side_reg[K_DQ].d) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= vld_reg[K_DQ];
        end
    end

    always_ff @(posedge clk)
    begin
        we_reg   <= we_next;
        col_reg  <= col_next;
        row_reg  <= row_next;
        idx_reg  <= idx_next;
        dout_reg <= dout_next;
        fend_reg <= side_reg[K_DQ].last;
    end

    assign result_valid = result_valid_reg;
    assign write_enable = we_reg;
    assign color_col    = col_reg;
    assign color_row    = row_reg;
    assign color_index  = idx_reg;
    assign depth_out_mm = dout_reg;
    assign frame_end    = fend_reg;

endmodule

@@ tb/depth_to_color_registration_checker.sv @@
module depth_to_color_registration_checker import dtcr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_D_W-1:0]    cfg_data,
    input  logic                  start,
    input  logic                  busy,
    input  logic [COORD_BITS-1:0] depth_col,
    input  logic [COORD_BITS-1:0] depth_row,
    input  logic [DEPTH_BITS-1:0] depth_mm,
    input  logic                  depth_valid,
    input  logic                  frame_last,
    input  logic                  result_valid,
    input  logic                  write_enable,
    input  logic [CC_W-1:0]       color_col,
    input  logic [CC_W-1:0]       color_row,
    input  logic [IDX_W-1:0]      color_index,
    input  logic [OUT_D_W-1:0]    depth_out_mm,
    input  logic                  frame_end,
    output int                    errors,
    output int                    pending
);

    typedef struct packed {
        logic               we;
        logic [CC_W-1:0]    col;
        logic [CC_W-1:0]    row;
        logic [IDX_W-1:0]   idx;
        logic [OUT_D_W-1:0] d;
        logic               last;
    } wr_cmd_t;

    wr_cmd_t     writes_due[$];
    logic [63:0] d_intr, c_intr, rot0, rot1, rot2, trans, csize;

    // n / m, rounded half away from zero
    function automatic longint round_div(longint n, longint unsigned m);
        longint unsigned mag, q;
        mag = n < 0 ? -n : n;
        q = (2 * mag + m) / (2 * m);
        return n < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint slot16(logic [63:0] w, int k);
        return longint'($signed(w[16*k +: 16]));
    endfunction

    function automatic longint rotate_row(logic [63:0] r, longint x, longint y, longint z,
                                          longint t);
        longint s, lim;
        lim = (64'sd1 <<< 44) - 1;
        s = slot16(r, 0) * x + slot16(r, 1) * y + slot16(r, 2) * z + t * (64'sd1 <<< 18);
        s = round_div(s, 64'd16384);
        if (s > lim) s = lim;
        if (s < -lim) s = -lim;
        return s;
    endfunction

    function automatic wr_cmd_t project_pixel(logic [11:0] col, logic [11:0] row,
                                              logic [15:0] d, logic ok, logic last);
        wr_cmd_t o;
        longint  nx, ny, x, y, z, px, py, pz, c, r, w, h;
        o = '0;
        o.last = last;
        w = csize[11:0];
        h = csize[23:12];
        if (ok && d_intr[15:0] != 0 && d_intr[31:16] != 0) begin
            nx = round_div((longint'(col) * 16 - longint'(d_intr[47:32])) * 65536,
                           d_intr[15:0]);
            ny = round_div((longint'(row) * 16 - longint'(d_intr[63:48])) * 65536,
                           d_intr[31:16]);
            x = round_div(longint'(d) * nx, 64'd4096);
            y = round_div(longint'(d) * ny, 64'd4096);
            z = longint'(d) * 16;
            px = rotate_row(rot0, x, y, z, longint'($signed(trans[19:0])));
            py = rotate_row(rot1, x, y, z, longint'($signed(trans[39:20])));
            pz = rotate_row(rot2, x, y, z, longint'($signed(trans[59:40])));
            if (pz > 0) begin
                c = round_div(px * longint'(c_intr[15:0]) + longint'(c_intr[47:32]) * pz,
                              pz * 16);
                r = round_div(py * longint'(c_intr[31:16]) + longint'(c_intr[63:48]) * pz,
                              pz * 16);
                if (c >= 0 && c < w && r >= 0 && r < h) begin
                    o.we  = 1'b1;
                    o.col = c[11:0];
                    o.row = r[11:0];
                    o.idx = 24'(r * w + c);
                    o.d   = d;
                end
            end
        end
        return o;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        wr_cmd_t e;
        if (!rst_n)
        begin
            d_intr = 0; c_intr = 0; trans = 0;
            rot0 = 64'd16384; rot1 = 64'd1073741824; rot2 = 64'd70368744177664;
            csize = 64'd1966720;
            writes_due.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    REG_DEPTH_INTR: d_intr = cfg_data;
                    REG_COLOR_INTR: c_intr = cfg_data;
                    REG_ROT_ROW0:   rot0 = cfg_data & 64'hFFFF_FFFF_FFFF;
                    REG_ROT_ROW1:   rot1 = cfg_data & 64'hFFFF_FFFF_FFFF;
                    REG_ROT_ROW2:   rot2 = cfg_data & 64'hFFFF_FFFF_FFFF;
                    REG_TRANS:      trans = cfg_data & 64'h0FFF_FFFF_FFFF_FFFF;
                    REG_COLOR_SIZE: csize = cfg_data & 64'hFF_FFFF;
                    default: ;
                endcase
            if (result_valid)
            begin
                if (writes_due.size() == 0)
                begin
                    report("unexpected result beat", 1, 0);
                end
                else
                begin
                    e = writes_due.pop_front();
                    if (write_enable !== e.we) report("write_enable", write_enable, e.we);
                    if (color_col !== e.col) report("color_col", color_col, e.col);
                    if (color_row !== e.row) report("color_row", color_row, e.row);
                    if (color_index !== e.idx) report("color_index", color_index, e.idx);
                    if (depth_out_mm !== e.d) report("depth_out_mm", depth_out_mm, e.d);
                    if (frame_end !== e.last) report("frame_end", frame_end, e.last);
                end
            end
            if (start && !busy)
                writes_due.push_back(project_pixel(depth_col, depth_row, depth_mm,
                                                   depth_valid, frame_last));
            pending = writes_due.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
// Stimulus and verdict for the depth-to-colour registration block.
// The checker alongside predicts every write command and compares; this
// module only produces pixel beats and register writes.
module tb_top;
    import dtcr_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_D_W-1:0]    cfg_data = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [COORD_BITS-1:0] depth_col = '0;
    logic [COORD_BITS-1:0] depth_row = '0;
    logic [DEPTH_BITS-1:0] depth_mm = '0;
    logic                  depth_valid = 1'b0;
    logic                  frame_last = 1'b0;
    logic                  result_valid;
    logic                  write_enable;
    logic [CC_W-1:0]       color_col;
    logic [CC_W-1:0]       color_row;
    logic [IDX_W-1:0]      color_index;
    logic [OUT_D_W-1:0]    depth_out_mm;
    logic                  frame_end;
    int                    errors;
    int                    pending;

    // 12-unit clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    depth_to_color_registration_top u_dut (.*);

    depth_to_color_registration_checker u_chk (.*);

    // Pack four Q12.4 values; arguments are in sixteenths
    function automatic logic [63:0] intr(int fx, int fy, int cx, int cy);
        return {16'(cy), 16'(cx), 16'(fy), 16'(fx)};
    endfunction

    function automatic logic [47:0] rot_row(int a, int b, int c);
        return {16'(c), 16'(b), 16'(a)};
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One pixel beat; returns once the block has taken it
    task automatic send_pixel(int col, int row, int d, bit ok, bit last);
        start       <= 1'b1;
        depth_col   <= COORD_BITS'(col);
        depth_row   <= COORD_BITS'(row);
        depth_mm    <= DEPTH_BITS'(d);
        depth_valid <= ok;
        frame_last  <= last;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Wait until every predicted write has come back, then let the pipe empty
    task automatic drain();
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    // Realistic sensor pair: VGA-ish depth into a colour frame
    task automatic load_camera_pair(int tx, int ty, int tz);
        write_reg(REG_DEPTH_INTR, intr(570 * 16, 570 * 16, 320 * 16, 240 * 16));
        write_reg(REG_COLOR_INTR, intr(525 * 16 + 5, 527 * 16, 319 * 16 + 8, 239 * 16));
        write_reg(REG_TRANS, {20'(tz), 20'(ty), 20'(tx)});
    endtask

    // Bursts of random pixels with random gaps; mostly plausible pixels
    task automatic random_pixels(int n);
        int burst;
        int col, row, d;
        burst = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                col = $urandom_range(0, 639);
                row = $urandom_range(0, 479);
                d   = $urandom_range(300, 8000);
            end
            else
            begin
                col = $urandom_range(0, 4095);
                row = $urandom_range(0, 4095);
                d   = $urandom_range(0, 65535);
            end
            send_pixel(col, row, d, $urandom_range(0, 9) != 0, $urandom_range(0, 15) == 0);
            if (--burst == 0)
            begin
                burst = $urandom_range(1, 12);
                // Some bursts run straight on, others leave a gap
                if ($urandom_range(0, 2) != 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end
            end
        end
        drain();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: depth focal lengths are zero, so every write is off
        send_pixel(320, 240, 1000, 1'b1, 1'b0);
        send_pixel(0, 0, 65535, 1'b1, 1'b1);
        drain();

        // Identity pose, colour frame 640 x 480 from reset
        load_camera_pair(0, 0, 0);
        send_pixel(320, 240, 1000, 1'b1, 1'b0);
        send_pixel(0, 0, 1000, 1'b1, 1'b0);
        send_pixel(639, 479, 1000, 1'b1, 1'b0);
        send_pixel(4095, 4095, 65535, 1'b1, 1'b1);
        send_pixel(0, 0, 0, 1'b1, 1'b0);          // zero depth, point on the lens
        send_pixel(100, 100, 65535, 1'b1, 1'b0);
        send_pixel(320, 240, 1500, 1'b0, 1'b1);   // no measurement
        send_pixel(2730, 1365, 21845, 1'b1, 1'b0);
        send_pixel(1365, 2730, 43690, 1'b1, 1'b0);
        send_pixel(600, 20, 1, 1'b1, 1'b1);
        drain();

        // Pose flipped so points land behind the colour camera
        write_reg(REG_ROT_ROW2, rot_row(0, 0, -16384));
        send_pixel(320, 240, 1000, 1'b1, 1'b0);
        send_pixel(10, 400, 5000, 1'b1, 1'b1);
        drain();

        // Extreme registers: huge translation and rotation drive saturation
        write_reg(REG_ROT_ROW0, 48'h7FFF_8000_7FFF);
        write_reg(REG_ROT_ROW1, 48'h8000_7FFF_8000);
        write_reg(REG_ROT_ROW2, rot_row(16384, 16384, 32767));
        write_reg(REG_TRANS, 64'h0FFF_FFFF_FFFF_FFFF);
        write_reg(REG_DEPTH_INTR, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_COLOR_INTR, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_COLOR_SIZE, 24'hFFF_FFF);
        send_pixel(0, 0, 65535, 1'b1, 1'b0);
        send_pixel(4095, 4095, 65535, 1'b1, 1'b1);
        send_pixel(4095, 0, 1, 1'b1, 1'b0);
        drain();

        // Zero-sized colour frame blocks every write
        write_reg(REG_DEPTH_INTR, intr(570 * 16, 570 * 16, 320 * 16, 240 * 16));
        write_reg(REG_COLOR_INTR, intr(525 * 16, 525 * 16, 320 * 16, 240 * 16));
        write_reg(REG_ROT_ROW0, rot_row(16384, 0, 0));
        write_reg(REG_ROT_ROW1, rot_row(0, 16384, 0));
        write_reg(REG_ROT_ROW2, rot_row(0, 0, 16384));
        write_reg(REG_TRANS, 64'd0);
        write_reg(REG_COLOR_SIZE, 24'h000_000);
        send_pixel(320, 240, 1000, 1'b1, 1'b0);
        send_pixel(100, 50, 2000, 1'b1, 1'b1);
        drain();

        // Random phases, each with its own plausible pose and frame size; the last uses the largest frame
        for (int ph = 0; ph < 4; ph++)
        begin
            load_camera_pair($signed($urandom_range(0, 200)) - 100,
                             $signed($urandom_range(0, 60)) - 30,
                             $signed($urandom_range(0, 40)) - 20);
            write_reg(REG_ROT_ROW0, rot_row(16384 - $urandom_range(0, 40),
                                            $signed($urandom_range(0, 400)) - 200,
                                            $signed($urandom_range(0, 400)) - 200));
            write_reg(REG_ROT_ROW1, rot_row($signed($urandom_range(0, 400)) - 200,
                                            16384 - $urandom_range(0, 40),
                                            $signed($urandom_range(0, 400)) - 200));
            write_reg(REG_ROT_ROW2, rot_row($signed($urandom_range(0, 400)) - 200,
                                            $signed($urandom_range(0, 400)) - 200,
                                            16384 - $urandom_range(0, 40)));
            write_reg(REG_COLOR_SIZE, ph == 3 ? 24'hFFF_FFF
                                     : {12'($urandom_range(240, 1080)),
                                        12'($urandom_range(320, 1920))});
            random_pixels(155);
        end

        if (errors == 0)
            $display("depth_to_color_registration_top verification clean");
        else
            $display("depth_to_color_registration_top verification failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legitimate run
    initial
    begin
        #3000000;
        $display("depth_to_color_registration_top verification failed");
        $finish;
    end

endmodule

@@ files.f @@
sv/dtcr_pkg.sv
sv/dtcr_ndiv.sv
sv/dtcr_pdiv.sv
sv/depth_to_color_registration_top.sv
tb/depth_to_color_registration_checker.sv
tb/tb_top.sv
